/* rtl/core/ritter_bounding_sphere_top_macros.svh */
// Assertion macros shared by the bounding sphere RTL.
// Needs signals named clock and reset in the including scope.
`ifndef RITTER_BOUNDING_SPHERE_TOP_MACROS_SVH
`define RITTER_BOUNDING_SPHERE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rbs_pkg.sv */
// Shared types, constants and helpers of the bounding sphere block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rbs_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_W        = 32;
   localparam int RAD_W          = 33;
   localparam int SQ_W           = 66;

   typedef logic [2:0][COORD_W-1:0] vec_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIST,
      OP_SPAN_PICK,
      OP_CENTER,
      OP_R2_SET,
      OP_R_SET,
      OP_READ,
      OP_PLATCH,
      OP_SQRT,
      OP_BOX_UPD,
      OP_GROW_R,
      OP_RSQ,
      OP_PREP,
      OP_MULK,
      OP_DIV
   } op_type;

   // Operations that only fit in a second code space.
   typedef enum logic [1:0] {
      XOP_NONE,
      XOP_CUPD,
      XOP_EMIT
   } xop_type;

   typedef enum logic [1:0] {
      SRC_SPAN,
      SRC_R2,
      SRC_BOX,
      SRC_RIT
   } src_type;

   typedef struct packed {
      op_type     op;
      xop_type    xop;
      src_type    src;
      logic [1:0] axis;
      logic       first;
      logic       dropped;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic dist_done;
      logic sqrt_done;
      logic div_done;
      logic gt;
   } stat_type;

   localparam cmd_type CMD_IDLE = '{op: OP_NOP, xop: XOP_NONE, src: SRC_SPAN,
                                    axis: 2'd0, first: 1'b0, dropped: 1'b0};

   // Signed midpoint, truncated toward zero.
   function automatic logic [COORD_W-1:0] half_sum(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      s = s + {{COORD_W{1'b0}}, s[COORD_W]};
      return s[COORD_W:1];
   endfunction

endpackage

/* rtl/core/rbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/rbs_ctrl.sv */
// Sequencer of the bounding sphere block: point intake, second pass, result.
// Depends on rbs_pkg; drives the datapath through cmd_type and reads stat_type.
`timescale 1ns / 1ps

module rbs_ctrl
   import rbs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          take,
   output cmd_type       cmd,
   output logic [AW-1:0] addr,
   input  stat_type      stat
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SPAN_GO, ST_SPAN_WAIT, ST_CENTER, ST_R2_GO, ST_R2_WAIT,
      ST_R_WAIT, ST_READ, ST_PLATCH, ST_BOX_GO, ST_BOX_WAIT, ST_BOX_SQRT,
      ST_RIT_GO, ST_RIT_WAIT, ST_GROW_SQRT, ST_RSQ, ST_PREP, ST_MULK,
      ST_DIV_GO, ST_DIV_WAIT, ST_NEXT, ST_EMIT, ST_FIN
   } state_type;

   state_type     state_ff;
   cmd_type       cmd_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] idx_ff;
   logic [1:0]    ax_ff;
   logic          drop_ff;
   logic          rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tready && req_tvalid;
   assign cmd        = cmd_ff;
   assign addr       = addr_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= CMD_IDLE;
         addr_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         ax_ff        <= 2'd0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_ff <= CMD_IDLE;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (count_ff < MAX_CNT) begin
                     cmd_ff.op    <= OP_LOAD;
                     cmd_ff.first <= (count_ff == '0);
                     addr_ff      <= count_ff[AW-1:0];
                     count_ff     <= count_ff + CNT_ONE;
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     ax_ff    <= 2'd0;
                     state_ff <= ST_SPAN_GO;
                  end
               end
            end
            ST_SPAN_GO: begin
               cmd_ff.op   <= OP_DIST;
               cmd_ff.src  <= SRC_SPAN;
               cmd_ff.axis <= ax_ff;
               state_ff    <= ST_SPAN_WAIT;
            end
            ST_SPAN_WAIT: begin
               if (stat.dist_done) begin
                  cmd_ff.op   <= OP_SPAN_PICK;
                  cmd_ff.axis <= ax_ff;
                  if (ax_ff == 2'd2) begin
                     state_ff <= ST_CENTER;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_SPAN_GO;
                  end
               end
            end
            ST_CENTER: begin
               cmd_ff.op <= OP_CENTER;
               state_ff  <= ST_R2_GO;
            end
            ST_R2_GO: begin
               cmd_ff.op  <= OP_DIST;
               cmd_ff.src <= SRC_R2;
               state_ff   <= ST_R2_WAIT;
            end
            ST_R2_WAIT: begin
               if (stat.dist_done) begin
                  cmd_ff.op <= OP_R2_SET;
                  state_ff  <= ST_R_WAIT;
               end
            end
            ST_R_WAIT: begin
               if (stat.sqrt_done) begin
                  cmd_ff.op <= OP_R_SET;
                  idx_ff    <= '0;
                  state_ff  <= ST_READ;
               end
            end
            ST_READ: begin
               cmd_ff.op <= OP_READ;
               addr_ff   <= idx_ff[AW-1:0];
               state_ff  <= ST_PLATCH;
            end
            ST_PLATCH: begin
               cmd_ff.op <= OP_PLATCH;
               state_ff  <= ST_BOX_GO;
            end
            ST_BOX_GO: begin
               cmd_ff.op  <= OP_DIST;
               cmd_ff.src <= SRC_BOX;
               state_ff   <= ST_BOX_WAIT;
            end
            ST_BOX_WAIT: begin
               if (stat.dist_done) begin
                  cmd_ff.op <= OP_SQRT;
                  state_ff  <= ST_BOX_SQRT;
               end
            end
            ST_BOX_SQRT: begin
               if (stat.sqrt_done) begin
                  cmd_ff.op <= OP_BOX_UPD;
                  state_ff  <= ST_RIT_GO;
               end
            end
            ST_RIT_GO: begin
               cmd_ff.op  <= OP_DIST;
               cmd_ff.src <= SRC_RIT;
               state_ff   <= ST_RIT_WAIT;
            end
            ST_RIT_WAIT: begin
               if (stat.dist_done) begin
                  if (stat.gt) begin
                     cmd_ff.op <= OP_SQRT;
                     state_ff  <= ST_GROW_SQRT;
                  end else begin
                     state_ff <= ST_NEXT;
                  end
               end
            end
            ST_GROW_SQRT: begin
               if (stat.sqrt_done) begin
                  cmd_ff.op <= OP_GROW_R;
                  state_ff  <= ST_RSQ;
               end
            end
            ST_RSQ: begin
               cmd_ff.op <= OP_RSQ;
               ax_ff     <= 2'd0;
               state_ff  <= ST_PREP;
            end
            ST_PREP: begin
               cmd_ff.op   <= OP_PREP;
               cmd_ff.axis <= ax_ff;
               state_ff    <= ST_MULK;
            end
            ST_MULK: begin
               cmd_ff.op <= OP_MULK;
               state_ff  <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               cmd_ff.op <= OP_DIV;
               state_ff  <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (stat.div_done) begin
                  cmd_ff.xop  <= XOP_CUPD;
                  cmd_ff.axis <= ax_ff;
                  if (ax_ff == 2'd2) begin
                     state_ff <= ST_NEXT;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_NEXT: begin
               if ((idx_ff + CNT_ONE) == count_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  idx_ff   <= idx_ff + CNT_ONE;
                  state_ff <= ST_READ;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  cmd_ff.xop     <= XOP_EMIT;
                  cmd_ff.dropped <= drop_ff;
                  state_ff       <= ST_FIN;
               end
            end
            ST_FIN: begin
               rsp_valid_ff <= 1'b1;
               count_ff     <= '0;
               drop_ff      <= 1'b0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/core/rbs_dpath.sv */
// Datapath of the bounding sphere block: point store, extremes, distance,
// square root and divide units, sphere registers. Depends on rbs_pkg, rbs_ram.
`timescale 1ns / 1ps

module rbs_dpath
   import rbs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [COORD_W-1:0] point_x,
   input  logic [COORD_W-1:0] point_y,
   input  logic [COORD_W-1:0] point_z,
   input  cmd_type            cmd,
   input  logic [AW-1:0]      addr,
   output stat_type           stat,
   output logic [COORD_W-1:0] center_x,
   output logic [COORD_W-1:0] center_y,
   output logic [COORD_W-1:0] center_z,
   output logic [RAD_W-1:0]   sphere_radius,
   output logic               overflow
);

   vec_type pin_ff, p_ff, c_ff, nc_ff, oc_ff;
   vec_type min_pt_ff [3];
   vec_type max_pt_ff [3];
   vec_type ram_rdata;

   logic [SQ_W-1:0]  best_ff, acc_ff, mul_ff, r2_ff;
   logic [1:0]       sel_ff;
   logic [RAD_W-1:0] dmag_ff, k_ff, r_ff, box_ff, dist_ff, orad_ff;
   logic             dneg_ff, oovf_ff;

   // Distance-squared unit.
   logic       drun_ff, ddone_ff;
   logic [2:0] dt_ff;
   src_type    dsrc_ff;
   logic [1:0] dax_ff;

   // Square root unit.
   logic             srun_ff, sdone_ff;
   logic [5:0]       scnt_ff;
   logic [SQ_W-1:0]  srad_ff;
   logic [34:0]      srem_ff;
   logic [RAD_W-1:0] sroot_ff;

   // Divider.
   logic             vrun_ff, vdone_ff;
   logic [5:0]       vcnt_ff;
   logic [RAD_W-1:0] vrem_ff, vnum_ff, vq_ff;

   vec_type          a_vec, b_vec;
   logic [1:0]       dk;
   logic [COORD_W:0] ddiff, dmag_next, pdiff;
   logic [RAD_W-1:0] mul_a, mul_b;
   logic [SQ_W-1:0]  product;
   logic [36:0]      s_rem2, s_trial, s_sub;
   logic             s_ge;
   logic [RAD_W:0]   v_rem2, v_sub;
   logic             v_ge;
   logic [RAD_W:0]   rsum;

   rbs_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_POINTS), .AW(AW)) u_store (
      .clock (clock),
      .we    (cmd.op == OP_LOAD),
      .waddr (addr),
      .wdata (pin_ff),
      .re    (cmd.op == OP_READ),
      .raddr (addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (dsrc_ff)
         SRC_SPAN: begin a_vec = min_pt_ff[dax_ff]; b_vec = max_pt_ff[dax_ff]; end
         SRC_R2:   begin a_vec = max_pt_ff[sel_ff]; b_vec = c_ff;              end
         SRC_BOX:  begin a_vec = p_ff;              b_vec = nc_ff;             end
         default:  begin a_vec = p_ff;              b_vec = c_ff;              end
      endcase
   end

   assign dk        = dt_ff[1:0];
   assign ddiff     = {a_vec[dk][COORD_W-1], a_vec[dk]} - {b_vec[dk][COORD_W-1], b_vec[dk]};
   assign dmag_next = ddiff[COORD_W] ? (~ddiff + 1'b1) : ddiff;
   assign pdiff     = {p_ff[cmd.axis][COORD_W-1], p_ff[cmd.axis]}
                    - {c_ff[cmd.axis][COORD_W-1], c_ff[cmd.axis]};

   // One shared 33 x 33 multiplier.
   always_comb begin
      if (drun_ff) begin
         mul_a = dmag_ff;
         mul_b = dmag_ff;
      end else if (cmd.op == OP_RSQ) begin
         mul_a = r_ff;
         mul_b = r_ff;
      end else begin
         mul_a = k_ff;
         mul_b = dmag_ff;
      end
   end
   assign product = mul_a * mul_b;

   assign s_rem2  = {srem_ff, srad_ff[SQ_W-1:SQ_W-2]};
   assign s_trial = {2'b00, sroot_ff, 2'b01};
   assign s_ge    = (s_rem2 >= s_trial);
   assign s_sub   = s_rem2 - s_trial;

   assign v_rem2 = {vrem_ff, vnum_ff[RAD_W-1]};
   assign v_ge   = (v_rem2 >= {1'b0, dist_ff});
   assign v_sub  = v_rem2 - {1'b0, dist_ff};

   assign rsum = {1'b0, r_ff} + {1'b0, sroot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         drun_ff  <= 1'b0;
         ddone_ff <= 1'b0;
         srun_ff  <= 1'b0;
         sdone_ff <= 1'b0;
         vrun_ff  <= 1'b0;
         vdone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         sdone_ff <= 1'b0;
         vdone_ff <= 1'b0;
         if (cmd.op == OP_DIST) begin
            drun_ff <= 1'b1;
         end else if (drun_ff && dt_ff == 3'd4) begin
            drun_ff  <= 1'b0;
            ddone_ff <= 1'b1;
         end
         if (cmd.op == OP_SQRT || cmd.op == OP_R2_SET) begin
            srun_ff <= 1'b1;
         end else if (srun_ff && scnt_ff == 6'd32) begin
            srun_ff  <= 1'b0;
            sdone_ff <= 1'b1;
         end
         if (cmd.op == OP_DIV) begin
            vrun_ff <= 1'b1;
         end else if (vrun_ff && vcnt_ff == 6'd32) begin
            vrun_ff  <= 1'b0;
            vdone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pin_ff <= {point_z, point_y, point_x};
      end

      // Distance-squared: difference, square, accumulate, one axis per cycle.
      if (cmd.op == OP_DIST) begin
         dt_ff   <= 3'd0;
         dsrc_ff <= cmd.src;
         dax_ff  <= cmd.axis;
         acc_ff  <= '0;
      end else if (drun_ff) begin
         dt_ff <= dt_ff + 3'd1;
         if (dt_ff < 3'd3) begin
            dmag_ff <= dmag_next;
         end
         if (dt_ff >= 3'd1 && dt_ff <= 3'd3) begin
            mul_ff <= product;
         end
         if (dt_ff >= 3'd2) begin
            acc_ff <= acc_ff + mul_ff;
         end
      end

      // Square root, two radicand bits per cycle.
      if (cmd.op == OP_SQRT || cmd.op == OP_R2_SET) begin
         scnt_ff  <= '0;
         srad_ff  <= acc_ff;
         srem_ff  <= '0;
         sroot_ff <= '0;
      end else if (srun_ff) begin
         scnt_ff  <= scnt_ff + 6'd1;
         srad_ff  <= {srad_ff[SQ_W-3:0], 2'b00};
         srem_ff  <= s_ge ? s_sub[34:0] : s_rem2[34:0];
         sroot_ff <= {sroot_ff[RAD_W-2:0], s_ge};
      end

      // Restoring divide, one quotient bit per cycle.
      if (cmd.op == OP_DIV) begin
         vcnt_ff <= '0;
         vrem_ff <= mul_ff[SQ_W-1:RAD_W];
         vnum_ff <= mul_ff[RAD_W-1:0];
         vq_ff   <= '0;
      end else if (vrun_ff) begin
         vcnt_ff <= vcnt_ff + 6'd1;
         vrem_ff <= v_ge ? v_sub[RAD_W-1:0] : v_rem2[RAD_W-1:0];
         vnum_ff <= {vnum_ff[RAD_W-2:0], 1'b0};
         vq_ff   <= {vq_ff[RAD_W-2:0], v_ge};
      end

      case (cmd.op)
         OP_LOAD: begin
            for (int a = 0; a < 3; a++) begin
               if (cmd.first || $signed(pin_ff[a]) < $signed(min_pt_ff[a][a])) begin
                  min_pt_ff[a] <= pin_ff;
               end
               if (cmd.first || $signed(pin_ff[a]) > $signed(max_pt_ff[a][a])) begin
                  max_pt_ff[a] <= pin_ff;
               end
            end
         end
         OP_SPAN_PICK: begin
            if (cmd.axis == 2'd0 || acc_ff > best_ff) begin
               best_ff <= acc_ff;
               sel_ff  <= cmd.axis;
            end
         end
         OP_CENTER: begin
            for (int a = 0; a < 3; a++) begin
               c_ff[a]  <= half_sum(min_pt_ff[sel_ff][a], max_pt_ff[sel_ff][a]);
               nc_ff[a] <= half_sum(min_pt_ff[a][a], max_pt_ff[a][a]);
            end
            box_ff <= '0;
         end
         OP_R2_SET:  r2_ff <= acc_ff;
         OP_R_SET:   r_ff  <= sroot_ff;
         OP_PLATCH:  p_ff  <= ram_rdata;
         OP_BOX_UPD: begin
            if (sroot_ff > box_ff) begin
               box_ff <= sroot_ff;
            end
         end
         OP_GROW_R: begin
            dist_ff <= sroot_ff;
            r_ff    <= rsum[RAD_W:1];
         end
         OP_RSQ:  r2_ff <= product;
         OP_PREP: begin
            dneg_ff <= pdiff[COORD_W];
            dmag_ff <= pdiff[COORD_W] ? (~pdiff + 1'b1) : pdiff;
            k_ff    <= (dist_ff > r_ff) ? (dist_ff - r_ff) : '0;
         end
         OP_MULK: mul_ff <= product;
         default: begin
         end
      endcase

      case (cmd.xop)
         XOP_CUPD: begin
            c_ff[cmd.axis] <= dneg_ff ? (c_ff[cmd.axis] - vq_ff[COORD_W-1:0])
                                      : (c_ff[cmd.axis] + vq_ff[COORD_W-1:0]);
         end
         XOP_EMIT: begin
            if (r_ff < box_ff) begin
               oc_ff   <= c_ff;
               orad_ff <= r_ff;
            end else begin
               oc_ff   <= nc_ff;
               orad_ff <= box_ff;
            end
            oovf_ff <= cmd.dropped;
         end
         default: begin
         end
      endcase
   end

   assign stat.busy      = drun_ff || srun_ff || vrun_ff;
   assign stat.dist_done = ddone_ff;
   assign stat.sqrt_done = sdone_ff;
   assign stat.div_done  = vdone_ff;
   assign stat.gt        = (acc_ff > r2_ff);

   assign center_x      = oc_ff[0];
   assign center_y      = oc_ff[1];
   assign center_z      = oc_ff[2];
   assign sphere_radius = orad_ff;
   assign overflow      = oovf_ff;

endmodule

/* rtl/core/ritter_bounding_sphere_top.sv */
// Top level of the bounding sphere block: controller plus datapath.
// Depends on rbs_pkg, rbs_ctrl, rbs_dpath and the assertion macro header.
//
// Usage. Points enter on the req_ stream one beat each; req_tlast marks the
// final point of a set. Every point is stored (up to MAX_POINTS) and folded
// into the per-axis extreme points, so within a set points stream in at one
// beat per cycle. Points beyond capacity are dropped and reported through
// rsp_tuser on the set's result.
// After the last beat, req_tready drops while the block builds the initial
// Ritter sphere and the center of the box sphere, then makes a second pass
// over the stored points. Each point's distance to the box center goes
// through a square root to update the box sphere radius, and the point is
// tested against the Ritter sphere; a point that grows it also takes a
// second square root and three divisions for the center update.
// One beat on rsp_ carries the smaller sphere. The result waits in an output
// register, so new points are accepted while it is stalled; the next result
// waits until that one has been taken.
// Reset is synchronous and active high; it empties the point set and clears
// any pending result.
`timescale 1ns / 1ps
`include "ritter_bounding_sphere_top_macros.svh"

module ritter_bounding_sphere_top
   import rbs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // point_x, point_y, point_z
   input  logic         req_tlast,   // last_point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // center_x, center_y, center_z, sphere_radius, zero pad
   output logic [0:0]   rsp_tuser    // overflow
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   cmd_type            dp_cmd;
   stat_type           dp_stat;
   logic [AW-1:0]      dp_addr;
   logic               dp_take;
   logic [COORD_W-1:0] cx, cy, cz;
   logic [RAD_W-1:0]   rad;
   logic               ovf;

   rbs_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .take       (dp_take),
      .cmd        (dp_cmd),
      .addr       (dp_addr),
      .stat       (dp_stat)
   );

   rbs_dpath #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .take          (dp_take),
      .point_x       (req_tdata[31:0]),
      .point_y       (req_tdata[63:32]),
      .point_z       (req_tdata[95:64]),
      .cmd           (dp_cmd),
      .addr          (dp_addr),
      .stat          (dp_stat),
      .center_x      (cx),
      .center_y      (cy),
      .center_z      (cz),
      .sphere_radius (rad),
      .overflow      (ovf)
   );

   // Result fields, lowest bit first, padded to whole bytes.
   assign rsp_tdata = {7'd0, rad, cz, cy, cx};
   assign rsp_tuser = ovf;

   // The output register is only rewritten while no result is pending.
   `RBS_ASSERT_NOW(a_emit_free, dp_cmd.xop == XOP_EMIT, !rsp_tvalid, "result overwritten")
   // Points are only taken while every arithmetic unit is idle.
   `RBS_ASSERT_NOW(a_ready_idle, req_tready, !dp_stat.busy, "point taken while busy")
   // The units run one at a time, so at most one finishes per cycle.
   `RBS_ASSERT_NOW(a_one_done, 1'b1,
      $onehot0({dp_stat.dist_done, dp_stat.sqrt_done, dp_stat.div_done}), "units overlap")
   // A divider start is followed by the divider being busy.
   `RBS_ASSERT_NEXT(a_start_busy, dp_cmd.op == OP_DIV, dp_stat.busy, "divider did not start")

endmodule

/* tb/testbench.sv */
// Self-checking bench for the bounding sphere block: streams point sets, predicts spheres.
// Depends on rbs_pkg and ritter_bounding_sphere_top.
`timescale 1ns / 1ps

module testbench;
   import rbs_pkg::*;

   localparam int CAP = 1024;
   localparam longint CYCLE_LIMIT = 64'd4_000_000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        last;
   } point_beat_t;

   typedef struct packed {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
      logic [32:0] rad;
      logic        ovf;
   } sphere_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   ritter_bounding_sphere_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Predictor state: the stored set, the extreme points and the drop flag.
   longint pts_x[CAP];
   longint pts_y[CAP];
   longint pts_z[CAP];
   longint extreme[18];
   int     n_stored;
   bit     any_dropped;

   point_beat_t pending_points[$];
   sphere_t     expected_spheres[$];
   int          mismatches;
   int          inputs_done;

   function automatic longint iabs(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Squared distance needs up to 66 bits, so it is kept at 128.
   function automatic logic [127:0] sq_dist(longint ax, longint ay, longint az,
                                            longint bx, longint by, longint bz);
      logic [127:0] s;
      logic [63:0]  d;
      s = 0;
      d = iabs(ax - bx); s += {64'd0, d} * {64'd0, d};
      d = iabs(ay - by); s += {64'd0, d} * {64'd0, d};
      d = iabs(az - bz); s += {64'd0, d} * {64'd0, d};
      return s;
   endfunction

   function automatic logic [63:0] root_floor(logic [127:0] v);
      logic [63:0] res, cand;
      res = 0;
      for (int b = 34; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
      end
      return res;
   endfunction

   function automatic longint half_trunc(longint a, longint b);
      longint s;
      s = a + b;
      return s / 2;
   endfunction

   // Closes a set: Ritter sphere grown over the stored points versus box sphere.
   function automatic sphere_t close_set();
      sphere_t      o;
      longint       c[3], nc[3], p[3];
      int           i1, i2;
      logic [127:0] best, span, r2, pd2;
      logic [63:0]  r, nr, boxr, pdist, k, m;
      longint       diff;
      o = '0;
      if (n_stored == 0) begin
         o.ovf = any_dropped;
         return o;
      end
      i1 = 0; i2 = 3;
      best = sq_dist(extreme[0], extreme[1], extreme[2], extreme[3], extreme[4], extreme[5]);
      for (int a = 1; a < 3; a++) begin
         span = sq_dist(extreme[6*a], extreme[6*a+1], extreme[6*a+2],
                        extreme[6*a+3], extreme[6*a+4], extreme[6*a+5]);
         if (span > best) begin
            best = span; i1 = 6*a; i2 = 6*a + 3;
         end
      end
      for (int a = 0; a < 3; a++) begin
         c[a]  = half_trunc(extreme[i1+a], extreme[i2+a]);
         nc[a] = half_trunc(extreme[6*a+a], extreme[6*a+3+a]);
      end
      r2 = sq_dist(extreme[i2], extreme[i2+1], extreme[i2+2], c[0], c[1], c[2]);
      r = root_floor(r2);
      boxr = 0;
      for (int i = 0; i < n_stored; i++) begin
         p[0] = pts_x[i]; p[1] = pts_y[i]; p[2] = pts_z[i];
         nr = root_floor(sq_dist(p[0], p[1], p[2], nc[0], nc[1], nc[2]));
         if (nr > boxr) boxr = nr;
         pd2 = sq_dist(p[0], p[1], p[2], c[0], c[1], c[2]);
         if (pd2 > r2) begin
            pdist = root_floor(pd2);
            r = (r + pdist) / 2;
            r2 = {64'd0, r} * {64'd0, r};
            k = pdist > r ? pdist - r : 0;
            for (int a = 0; a < 3; a++) begin
               diff = p[a] - c[a];
               m = 64'(({64'd0, k} * {64'd0, 64'(iabs(diff))}) / {64'd0, pdist});
               c[a] = diff < 0 ? c[a] - longint'(m) : c[a] + longint'(m);
            end
         end
      end
      if (r < boxr) begin
         o.cx = c[0][31:0]; o.cy = c[1][31:0]; o.cz = c[2][31:0]; o.rad = r[32:0];
      end else begin
         o.cx = nc[0][31:0]; o.cy = nc[1][31:0]; o.cz = nc[2][31:0]; o.rad = boxr[32:0];
      end
      o.ovf = any_dropped;
      return o;
   endfunction

   // Folds one accepted beat into the predictor.
   task automatic absorb_point(point_beat_t b);
      longint p[3];
      bit     take;
      p[0] = longint'(signed'(b.x));
      p[1] = longint'(signed'(b.y));
      p[2] = longint'(signed'(b.z));
      if (n_stored < CAP) begin
         pts_x[n_stored] = p[0]; pts_y[n_stored] = p[1]; pts_z[n_stored] = p[2];
         for (int a = 0; a < 3; a++) begin
            for (int e = 0; e < 2; e++) begin
               take = n_stored == 0 ||
                      (e == 0 ? p[a] < extreme[6*a+3*e+a] : p[a] > extreme[6*a+3*e+a]);
               if (take)
                  for (int k = 0; k < 3; k++) extreme[6*a+3*e+k] = p[k];
            end
         end
         n_stored++;
      end else begin
         any_dropped = 1;
      end
      if (b.last) begin
         expected_spheres.push_back(close_set());
         n_stored = 0;
         any_dropped = 0;
      end
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Driver: bursts of random length separated by random gaps.
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
         req_tlast  <= 0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_point({req_tdata[31:0], req_tdata[63:32], req_tdata[95:64], req_tlast});
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_points.size() == 0) begin
               req_tvalid <= 0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               point_beat_t nb;
               nb = pending_points.pop_front();
               req_tvalid <= 1;
               req_tdata  <= {nb.z, nb.y, nb.x};
               req_tlast  <= nb.last;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Monitor: the receiver stalls in a pattern of its own and each beat is checked.
   int stall_phase;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         rsp_tready  <= (stall_phase % 97) > 40 ? 1'b1 : ($urandom_range(0, 2) != 0);
         if (rsp_tvalid && rsp_tready) begin
            sphere_t got, want;
            got.cx  = rsp_tdata[31:0];
            got.cy  = rsp_tdata[63:32];
            got.cz  = rsp_tdata[95:64];
            got.rad = rsp_tdata[128:96];
            got.ovf = rsp_tuser[0];
            if (expected_spheres.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = expected_spheres.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp c=(%h %h %h) r=%h o=%b got c=(%h %h %h) r=%h o=%b",
                              want.cx, want.cy, want.cz, want.rad, want.ovf,
                              got.cx, got.cy, got.cz, got.rad, got.ovf);
               end
            end
         end
      end
   end

   // Watchdog.
   longint cycles;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8000)) - 4000);
         default: return 32'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   task automatic add_set(int n, int mode);
      point_beat_t b;
      for (int i = 0; i < n; i++) begin
         b.x = rand_coord(mode); b.y = rand_coord(mode); b.z = rand_coord(mode);
         b.last = (i == n - 1);
         pending_points.push_back(b);
      end
   endtask

   initial begin
      point_beat_t b;
      int made, n;
      cycles = 0;
      mismatches = 0;
      n_stored = 0;
      any_dropped = 0;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tlast = 0; rsp_tready = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed: a single point, coordinate extremes, ties, and an overflowing set.
      b = '{32'h0, 32'h0, 32'h0, 1'b1};
      pending_points.push_back(b);
      b = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0}; pending_points.push_back(b);
      b = '{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1}; pending_points.push_back(b);
      b = '{32'h100, 32'h100, 32'h100, 1'b0}; pending_points.push_back(b);
      b = '{32'h100, 32'h100, 32'h100, 1'b0}; pending_points.push_back(b);
      b = '{32'hffffff00, 32'hffffff00, 32'hffffff00, 1'b1}; pending_points.push_back(b);
      b = '{32'h0, 32'h0, 32'h0, 1'b0}; pending_points.push_back(b);
      b = '{32'h400, 32'h0, 32'h0, 1'b0}; pending_points.push_back(b);
      b = '{32'h0, 32'h400, 32'h0, 1'b0}; pending_points.push_back(b);
      b = '{32'h0, 32'h0, 32'h400, 1'b0}; pending_points.push_back(b);
      b = '{32'h300, 32'h300, 32'h300, 1'b1}; pending_points.push_back(b);
      add_set(6, 0);
      // Capacity exceeded: drops flagged, last point itself dropped.
      add_set(CAP + 3, 1);

      // Random sets, mostly small, covering all coordinate ranges.
      made = 0;
      while (made < 300) begin
         n = $urandom_range(1, 12);
         add_set(n, $urandom_range(0, 2));
         made += n;
      end

      wait (pending_points.size() == 0 && !req_tvalid);
      wait (expected_spheres.size() == 0);
      repeat (500) @(posedge clock);
      if (mismatches == 0 && expected_spheres.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rbs_pkg.sv
rtl/core/rbs_ram.sv
rtl/core/rbs_ctrl.sv
rtl/core/rbs_dpath.sv
rtl/core/ritter_bounding_sphere_top.sv
tb/testbench.sv
